@@ sv/deq_pkg.sv @@
// Shared types and constants for the double-ended queue.
package deq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ReqW  = 3;
  localparam int unsigned StatW = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_DUMP       = 3'd4
  } req_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    req_e                    req;
    logic signed [DataW-1:0] value;
  } cmd_t;

endpackage

@@ sv/deq_if.sv @@
// Request and result channel interfaces of the double-ended queue.
interface deq_req_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  req_type;
  logic signed [31:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface deq_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic        [1:0]  status;
  logic               last;

  modport source (output valid, output result_value, output status, output last,
                  input ready);
  modport sink   (input valid, input result_value, input status, input last,
                  output ready);
endinterface

@@ sv/double_ended_queue_top.sv @@
// Top level of the bounded double-ended queue.
//
//   channel  dir  payload                           role
//   req_i    in   req_type[2:0], push_value[31:0]   one request per handshake
//   rsp_o    out  result_value[31:0], status, last  results, last marks the final one
//
// Push: one result, written by the executor into the result register. Pop: one result
// (storage read, then the result register). Dump of N entries: N results, streamed
// through the single storage read port.
// A two-entry request queue lets intake continue while the executor stalls on rsp_o.
// Reset clears indices, counts and valid flags; the storage is not cleared.
module double_ended_queue_top
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_req_if.sink   req_i,
  deq_rsp_if.source rsp_o
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  deq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .rsp_o       (rsp_o)
  );

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != ST_OK) |-> (rsp_o.result_value == '0) && rsp_o.last)
    else $error("error result carries data or is not final");

  a_cmd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
    else $error("queued command lost while executor stalled");

  a_cmd_enq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready && !cmd_valid && (req_i.req_type <= REQ_DUMP) |=> cmd_valid)
    else $error("accepted request not queued");
`endif

endmodule

@@ sv/deq_front.sv @@
// Request intake: drops unused codes and buffers commands in a two-entry queue.
module deq_front
  import deq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_req_if.sink   req_i,
  output logic      cmd_valid_o,
  input  logic      cmd_ready_i,
  output cmd_t      cmd_o
);

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  cmd_t             q_mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] n_q, n_d;
  logic             code_ok;
  logic             push;
  logic             pop;

  always_comb begin
    code_ok = req_i.req_type inside {REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_POP_FRONT,
                                     REQ_POP_BACK, REQ_DUMP};
  end

  assign req_i.ready = (n_q != QCntW'(QDepth));
  assign push        = req_i.valid && req_i.ready && code_ok;
  assign cmd_valid_o = (n_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem_q[rd_q];

  always_comb begin
    wr_d = push ? wr_q + 1'b1 : wr_q;
    rd_d = pop ? rd_q + 1'b1 : rd_q;
    n_d  = n_q;
    if (push && !pop) begin
      n_d = n_q + 1'b1;
    end else if (pop && !push) begin
      n_d = n_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      n_q  <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      n_q  <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_q] <= '{req: req_e'(req_i.req_type), value: req_i.push_value};
    end
  end

endmodule

@@ sv/deq_back.sv @@
// Command execution: ring buffer storage, front index, count and result register.
module deq_back
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  cmd_t      cmd_i,
  deq_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam logic [CntW-1:0] DepthC  = CntW'(DEPTH);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(DEPTH - 1);

  typedef enum logic {S_IDLE, S_READ} state_e;

  function automatic logic [IdxW-1:0] ring_add(logic [IdxW-1:0] base,
                                               logic [CntW-1:0] off);
    logic [SumW-1:0] sum;
    sum = SumW'(base) + SumW'(off);
    if (sum >= SumW'(DEPTH)) begin
      sum = sum - SumW'(DEPTH);
    end
    return sum[IdxW-1:0];
  endfunction

  logic [DataW-1:0] mem_q [DEPTH];
  logic [DataW-1:0] rd_data_q;

  state_e           state_q, state_d;
  logic [IdxW-1:0]  front_q, front_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  off_q, off_d;
  logic             rlast_q, rlast_d;
  logic             ov_q, ov_d;
  logic [DataW-1:0] oval_q, oval_d;
  status_e          ost_q, ost_d;
  logic             olast_q, olast_d;

  logic             out_free;
  logic             we;
  logic [IdxW-1:0]  waddr;
  logic             re;
  logic [IdxW-1:0]  raddr;

  assign out_free = !ov_q || rsp_o.ready;

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    cnt_d       = cnt_q;
    off_d       = off_q;
    rlast_d     = rlast_q;
    ov_d        = ov_q && !rsp_o.ready;
    oval_d      = oval_q;
    ost_d       = ost_q;
    olast_d     = olast_q;
    cmd_ready_o = 1'b0;
    we          = 1'b0;
    waddr       = front_q;
    re          = 1'b0;
    raddr       = front_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o = 1'b1;
          ov_d        = 1'b1;
          olast_d     = 1'b1;
          case (cmd_i.req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              if (cnt_q == DepthC) begin
                oval_d = '0;
                ost_d  = ST_FULL;
              end else begin
                we = 1'b1;
                if (cmd_i.req == REQ_PUSH_FRONT) begin
                  front_d = (front_q == '0) ? IdxLast : front_q - 1'b1;
                  waddr   = front_d;
                end else begin
                  waddr = ring_add(front_q, cnt_q);
                end
                cnt_d  = cnt_q + 1'b1;
                oval_d = cmd_i.value;
                ost_d  = ST_OK;
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              if (cnt_q == '0) begin
                oval_d = '0;
                ost_d  = ST_EMPTY;
              end else begin
                ov_d = ov_q && !rsp_o.ready;
                re   = 1'b1;
                if (cmd_i.req == REQ_POP_FRONT) begin
                  raddr   = front_q;
                  front_d = ring_add(front_q, CntW'(1));
                end else begin
                  raddr = ring_add(front_q, CntW'(cnt_q - 1'b1));
                end
                cnt_d   = cnt_q - 1'b1;
                rlast_d = 1'b1;
                state_d = S_READ;
              end
            end
            REQ_DUMP: begin
              if (cnt_q == '0) begin
                oval_d = '0;
                ost_d  = ST_EMPTY;
              end else begin
                ov_d    = ov_q && !rsp_o.ready;
                re      = 1'b1;
                raddr   = front_q;
                off_d   = CntW'(1);
                rlast_d = (cnt_q == CntW'(1));
                state_d = S_READ;
              end
            end
            default: begin
              ov_d = ov_q && !rsp_o.ready;
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          ov_d    = 1'b1;
          oval_d  = rd_data_q;
          ost_d   = ST_OK;
          olast_d = rlast_q;
          if (rlast_q) begin
            state_d = S_IDLE;
          end else begin
            re      = 1'b1;
            raddr   = ring_add(front_q, off_q);
            off_d   = off_q + 1'b1;
            rlast_d = (CntW'(off_q + 1'b1) == cnt_q);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      cnt_q   <= '0;
      off_q   <= '0;
      rlast_q <= 1'b0;
      ov_q    <= 1'b0;
      oval_q  <= '0;
      ost_q   <= ST_OK;
      olast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      cnt_q   <= cnt_d;
      off_q   <= off_d;
      rlast_q <= rlast_d;
      ov_q    <= ov_d;
      oval_q  <= oval_d;
      ost_q   <= ost_d;
      olast_q <= olast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= cmd_i.value;
    end
    if (re) begin
      rd_data_q <= mem_q[raddr];
    end
  end

  assign rsp_o.valid        = ov_q;
  assign rsp_o.result_value = oval_q;
  assign rsp_o.status       = ost_q;
  assign rsp_o.last         = olast_q;

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the double-ended queue: shadow deque, random requests and stalls.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import deq_pkg::*;

  localparam int unsigned Depth = 32;
  localparam logic [ReqW-1:0] ReqUnusedLo = 3'd5;
  localparam logic [ReqW-1:0] ReqUnusedHi = 3'd7;

  typedef struct {
    logic signed [DataW-1:0] value;
    status_e                 status;
    logic                    last;
  } deq_result_t;

  // Shadow deque: mirrors the ring buffer and queues the results each request should produce.
  class deque_shadow;
    logic signed [DataW-1:0] words [Depth];
    int unsigned             head;
    int unsigned             fill;
    deq_result_t             pending_results[$];
    int unsigned             errors;

    function new();
      head   = 0;
      fill   = 0;
      errors = 0;
    endfunction

    function void expect_result(logic signed [DataW-1:0] value, status_e status, logic last);
      deq_result_t r;
      r.value  = value;
      r.status = status;
      r.last   = last;
      pending_results.push_back(r);
    endfunction

    function void note_request(logic [ReqW-1:0] code, logic signed [DataW-1:0] value);
      int unsigned i;
      case (code)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (fill >= Depth) begin
            expect_result('0, ST_FULL, 1'b1);
          end else begin
            if (code == REQ_PUSH_FRONT) begin
              head = (head + Depth - 1) % Depth;
              words[head] = value;
            end else begin
              words[(head + fill) % Depth] = value;
            end
            fill++;
            expect_result(value, ST_OK, 1'b1);
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK: begin
          if (fill == 0) begin
            expect_result('0, ST_EMPTY, 1'b1);
          end else begin
            if (code == REQ_POP_FRONT) begin
              expect_result(words[head], ST_OK, 1'b1);
              head = (head + 1) % Depth;
            end else begin
              expect_result(words[(head + fill - 1) % Depth], ST_OK, 1'b1);
            end
            fill--;
          end
        end
        REQ_DUMP: begin
          if (fill == 0) begin
            expect_result('0, ST_EMPTY, 1'b1);
          end else begin
            for (i = 0; i < fill; i++) begin
              expect_result(words[(head + i) % Depth], ST_OK, i + 1 == fill);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic signed [DataW-1:0] value, logic [StatW-1:0] status, logic last);
      deq_result_t exp;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result value=%0d status=%0d last=%0b",
                         value, status, last));
      end else begin
        exp = pending_results.pop_front();
        if (value !== exp.value)
          report($sformatf("value %0d, expected %0d", value, exp.value));
        if (status !== exp.status)
          report($sformatf("status %0d, expected %0d", status, exp.status));
        if (last !== exp.last)
          report($sformatf("last %0b, expected %0b", last, exp.last));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  deq_req_if req_bus ();
  deq_rsp_if rsp_bus ();

  double_ended_queue_top #(
    .DEPTH(Depth)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  deque_shadow shadow = new();
  int unsigned requests_taken = 0;
  int unsigned real_requests  = 0;
  bit          calm           = 1'b0;
  bit          sender_gaps    = 1'b1;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready)
      shadow.check_result(rsp_bus.result_value, rsp_bus.status, rsp_bus.last);
  end

  // Result side: random ready, one long hold-off to back the block up.
  initial begin
    bit pressure_done;
    pressure_done = 1'b0;
    rsp_bus.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!pressure_done && !calm && requests_taken >= 60) begin
        rsp_bus.ready <= 1'b0;
        repeat (200) @(posedge clk_i);
        pressure_done = 1'b1;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        rsp_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        rsp_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
    end
  end

  task send_request(logic [ReqW-1:0] code, logic signed [DataW-1:0] value);
    if (!calm && sender_gaps && $urandom_range(0, 4) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= code;
    req_bus.push_value <= value;
    do @(posedge clk_i); while (!req_bus.ready);
    shadow.note_request(code, value);
    requests_taken++;
    if (code <= REQ_DUMP) real_requests++;
    if (real_requests >= 165) calm = 1'b1;
  endtask

  task send_push(logic signed [DataW-1:0] value);
    send_request($urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, value);
  endtask

  task send_pop();
    send_request($urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT, '0);
  endtask

  initial begin
    int unsigned k;
    int unsigned sel;
    logic [ReqW-1:0] code;
    req_bus.valid      <= 1'b0;
    req_bus.req_type   <= REQ_PUSH_FRONT;
    req_bus.push_value <= '0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);

    // directed: empty cases, unused codes, extreme words, both ends
    send_request(REQ_POP_FRONT, '0);
    send_request(REQ_POP_BACK, 32'sd12345);
    send_request(REQ_DUMP, '0);
    for (code = ReqUnusedLo; code != REQ_PUSH_FRONT; code++)
      send_request(code, 32'sh7fff_ffff);
    send_request(REQ_PUSH_FRONT, 32'sh7fff_ffff);
    send_request(REQ_PUSH_BACK, 32'sh8000_0000);
    send_request(REQ_PUSH_FRONT, 32'sd0);
    send_request(REQ_PUSH_BACK, -32'sd1);
    send_request(REQ_PUSH_FRONT, 32'sh5555_5555);
    send_request(REQ_PUSH_BACK, 32'shaaaa_aaaa);
    send_request(REQ_DUMP, '0);
    send_request(REQ_POP_BACK, '0);
    send_request(REQ_POP_FRONT, '0);
    send_request(REQ_DUMP, '0);
    send_request(REQ_POP_FRONT, '0);
    send_request(REQ_POP_BACK, '0);
    send_request(REQ_POP_FRONT, '0);
    send_request(REQ_POP_BACK, '0);
    send_request(REQ_DUMP, '0);

    // random: fill-to-full, drain-to-empty, mixed and noise segments
    while (real_requests < 195) begin
      sender_gaps = $urandom_range(0, 2) != 0;
      sel = $urandom_range(0, 9);
      if (sel <= 2) begin
        k = Depth - shadow.fill + $urandom_range(1, 3);
        repeat (k) send_push($urandom);
        send_request(REQ_DUMP, $urandom);
      end else if (sel <= 5) begin
        k = shadow.fill + $urandom_range(1, 2);
        repeat (k) begin
          if ($urandom_range(0, 9) == 0) send_request(REQ_DUMP, $urandom);
          else send_pop();
        end
      end else if (sel <= 8) begin
        repeat (12) begin
          k = $urandom_range(0, 15);
          if (k <= 5) send_push($urandom);
          else if (k <= 11) send_pop();
          else if (k <= 14) send_request(REQ_DUMP, $urandom);
          else send_request(ReqW'($urandom_range(ReqUnusedLo, ReqUnusedHi)), $urandom);
        end
      end else begin
        repeat (4) send_request(ReqW'($urandom_range(0, 7)), $urandom);
      end
    end
    req_bus.valid <= 1'b0;

    while (shadow.pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (shadow.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
